/* rtl/kmnc_pkg.sv */
// Shared types and constants for the k-means nearest-centroid unit.
// Holds the sequencer state type, the transaction mode codes and the default sizes.
// No dependencies.
`timescale 1ns / 1ps

package kmnc_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_CENTROIDS_DEF = 1024;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int COUNT_WIDTH_DEF   = 20;

  // Field widths that the port list fixes.
  localparam int MODE_W    = 2;
  localparam int ENTRY_W   = 10;
  localparam int NUMC_W    = 11;
  localparam int CLUSTER_W = 10;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CNT_RD,
    ST_CNT_WR
  } st_t;

  // Status of the distance pipeline as seen by the sequencer.
  typedef struct packed {
    logic vld;   // a finished distance is on the output this cycle
    logic busy;  // any stage, output included, holds a valid entry
  } dist_stat_t;

endpackage

/* rtl/kmnc_dist_unit.sv */
// Pipelined squared-distance unit: one point against one centroid per cycle.
// Three stages: absolute differences, squares, sum of squares.
// Depends on kmnc_pkg.
`timescale 1ns / 1ps

module kmnc_dist_unit #(
  parameter int COORD_WIDTH = kmnc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic signed [COORD_WIDTH-1:0]   pt_x,
  input  logic signed [COORD_WIDTH-1:0]   pt_y,
  input  logic signed [COORD_WIDTH-1:0]   pt_z,
  input  logic        [3*COORD_WIDTH-1:0] cent,
  output logic        [2*COORD_WIDTH+1:0] sq_dist,
  output kmnc_pkg::dist_stat_t            stat
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * COORD_WIDTH + 2;

  logic signed [CW-1:0] cx, cy, cz;
  logic signed [CW:0]   dx, dy, dz;
  logic signed [CW:0]   ax, ay, az;

  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [CW-1:0] abs_x_r, abs_y_r, abs_z_r;
  logic [2*CW-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic [DW-1:0] dist_r;

  assign cx = signed'(cent[3*CW-1:2*CW]);
  assign cy = signed'(cent[2*CW-1:CW]);
  assign cz = signed'(cent[CW-1:0]);

  // One extra bit keeps the difference exact; its magnitude fits in CW bits.
  assign dx = {pt_x[CW-1], pt_x} - {cx[CW-1], cx};
  assign dy = {pt_y[CW-1], pt_y} - {cy[CW-1], cy};
  assign dz = {pt_z[CW-1], pt_z} - {cz[CW-1], cz};
  assign ax = dx[CW] ? -dx : dx;
  assign ay = dy[CW] ? -dy : dy;
  assign az = dz[CW] ? -dz : dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    abs_x_r <= ax[CW-1:0];
    abs_y_r <= ay[CW-1:0];
    abs_z_r <= az[CW-1:0];
    sq_x_r  <= abs_x_r * abs_x_r;
    sq_y_r  <= abs_y_r * abs_y_r;
    sq_z_r  <= abs_z_r * abs_z_r;
    dist_r  <= DW'(sq_x_r) + DW'(sq_y_r) + DW'(sq_z_r);
  end

  assign sq_dist   = dist_r;
  assign stat.vld  = s3_vld_r;
  assign stat.busy = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule

/* rtl/kmeans_nearest_centroid_unit.sv */
// Top level of the k-means nearest-centroid unit: sequencer, centroid table,
// per-cluster count table and the configuration register.
// Depends on kmnc_pkg and kmnc_dist_unit.
`timescale 1ns / 1ps

// A load transaction writes one centroid in the cycle it is taken; busy stays low and the
// next transaction can follow at once. A clear transaction sweeps the count table one entry
// per cycle, busy until it ends; the same sweep runs after reset, during which
// configuration writes are still taken. A classify transaction reads one centroid per cycle
// from the table's single read port and streams it through the distance pipeline, so it
// holds busy while searching N entries, N being num_centroids clipped to 1..MAX_CENTROIDS.
// Its result appears for one cycle on out_valid as busy falls; the receiver cannot stall it.
// Classifying against an entry that was never loaded gives an undefined answer.

module kmeans_nearest_centroid_unit #(
  parameter int MAX_CENTROIDS = kmnc_pkg::MAX_CENTROIDS_DEF,
  parameter int COORD_WIDTH   = kmnc_pkg::COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH   = kmnc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [kmnc_pkg::MODE_W-1:0]   in_mode,
  input  logic        [kmnc_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic signed [COORD_WIDTH-1:0]        in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]        in_coord_y,
  input  logic signed [COORD_WIDTH-1:0]        in_coord_z,
  output logic                                 out_valid,
  output logic        [kmnc_pkg::CLUSTER_W-1:0] out_nearest_cluster,
  output logic        [COUNT_WIDTH-1:0]        out_cluster_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [kmnc_pkg::NUMC_W-1:0]   cfg_num_centroids
);

  localparam int AW = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CW = COORD_WIDTH;
  localparam int DW = 2 * COORD_WIDTH + 2;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CENTROIDS - 1);

  kmnc_pkg::st_t state_r, state_nxt;

  logic [kmnc_pkg::NUMC_W-1:0] numc_r, numc_nxt;
  logic signed [CW-1:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic [AW-1:0] scan_idx_r, scan_idx_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic [DW-1:0] best_dist_r, best_dist_nxt;
  logic          rd_vld_r;
  logic [3*CW-1:0] cent_q_r;
  logic [COUNT_WIDTH-1:0] cnt_q_r;
  logic          out_valid_r, out_valid_nxt;
  logic [kmnc_pkg::CLUSTER_W-1:0] out_cluster_r, out_cluster_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r, out_count_nxt;

  logic [3*CW-1:0]        cent_mem [MAX_CENTROIDS];
  logic [COUNT_WIDTH-1:0] cnt_mem  [MAX_CENTROIDS];

  logic          accept;
  logic [31:0]   entry_ext, numc_ext, neff, neff_m1, best_ext;
  logic          load_en;
  logic [AW-1:0] load_addr;
  logic [AW-1:0] last_calc;
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_inc;
  logic [DW-1:0] sq_dist;
  kmnc_pkg::dist_stat_t stat;

  assign accept    = start && (state_r == kmnc_pkg::ST_IDLE);
  assign busy      = (state_r != kmnc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign entry_ext = 32'(in_entry_index);
  assign load_addr = entry_ext[AW-1:0];
  assign load_en   = accept && (in_mode == kmnc_pkg::MODE_LOAD)
                     && (entry_ext < 32'(MAX_CENTROIDS));

  // A count of zero searches entry 0 alone; a count past the table searches the whole table.
  always_comb begin
    numc_ext = 32'(numc_r);
    if (numc_ext == 32'd0) begin
      neff = 32'd1;
    end else if (numc_ext > 32'(MAX_CENTROIDS)) begin
      neff = 32'(MAX_CENTROIDS);
    end else begin
      neff = numc_ext;
    end
    neff_m1 = neff - 32'd1;
  end
  assign last_calc = neff_m1[AW-1:0];

  assign best_ext = 32'(best_r);
  assign cnt_inc  = (&cnt_q_r) ? cnt_q_r : cnt_q_r + 1'b1;

  assign cnt_we    = (state_r == kmnc_pkg::ST_CLEAR) || (state_r == kmnc_pkg::ST_CNT_WR);
  assign cnt_waddr = (state_r == kmnc_pkg::ST_CLEAR) ? clr_addr_r : best_r;
  assign cnt_wdata = (state_r == kmnc_pkg::ST_CLEAR) ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (load_en) begin
      cent_mem[load_addr] <= {in_coord_x, in_coord_y, in_coord_z};
    end
    cent_q_r <= cent_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q_r <= cnt_mem[best_r];
  end

  kmnc_dist_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .pt_x    (px_r),
    .pt_y    (py_r),
    .pt_z    (pz_r),
    .cent    (cent_q_r),
    .sq_dist (sq_dist),
    .stat    (stat)
  );

  always_comb begin
    state_nxt       = state_r;
    numc_nxt        = numc_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    pz_nxt          = pz_r;
    scan_idx_nxt    = scan_idx_r;
    last_nxt        = last_r;
    clr_addr_nxt    = clr_addr_r;
    cmp_idx_nxt     = cmp_idx_r;
    best_nxt        = best_r;
    best_dist_nxt   = best_dist_r;
    out_valid_nxt   = 1'b0;
    out_cluster_nxt = out_cluster_r;
    out_count_nxt   = out_count_r;

    if (cfg_valid && cfg_ready) begin
      numc_nxt = cfg_num_centroids;
    end

    // Distances come back in table order, so a running index tracks which entry each is.
    // Only a strictly smaller distance replaces the best, which keeps the lower index on ties.
    if (stat.vld) begin
      cmp_idx_nxt = cmp_idx_r + 1'b1;
      if ((cmp_idx_r == '0) || (sq_dist < best_dist_r)) begin
        best_nxt      = cmp_idx_r;
        best_dist_nxt = sq_dist;
      end
    end

    case (state_r)
      kmnc_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clr_addr_nxt = '0;
          state_nxt    = kmnc_pkg::ST_IDLE;
        end
      end
      kmnc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            kmnc_pkg::MODE_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = kmnc_pkg::ST_CLEAR;
            end
            kmnc_pkg::MODE_CLASSIFY: begin
              px_nxt       = in_coord_x;
              py_nxt       = in_coord_y;
              pz_nxt       = in_coord_z;
              scan_idx_nxt = '0;
              cmp_idx_nxt  = '0;
              last_nxt     = last_calc;
              state_nxt    = kmnc_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      kmnc_pkg::ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == last_r) begin
          state_nxt = kmnc_pkg::ST_DRAIN;
        end
      end
      kmnc_pkg::ST_DRAIN: begin
        if (!rd_vld_r && !stat.busy) begin
          state_nxt = kmnc_pkg::ST_CNT_RD;
        end
      end
      kmnc_pkg::ST_CNT_RD: begin
        state_nxt = kmnc_pkg::ST_CNT_WR;
      end
      kmnc_pkg::ST_CNT_WR: begin
        out_valid_nxt   = 1'b1;
        out_cluster_nxt = best_ext[kmnc_pkg::CLUSTER_W-1:0];
        out_count_nxt   = cnt_inc;
        state_nxt       = kmnc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kmnc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmnc_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      numc_r      <= kmnc_pkg::NUMC_W'(1);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      numc_r      <= numc_nxt;
      rd_vld_r    <= (state_r == kmnc_pkg::ST_SCAN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    pz_r          <= pz_nxt;
    scan_idx_r    <= scan_idx_nxt;
    last_r        <= last_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    best_r        <= best_nxt;
    best_dist_r   <= best_dist_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_cluster = out_cluster_r;
  assign out_cluster_count   = out_count_r;

`ifndef SYNTH
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == kmnc_pkg::ST_CNT_WR))
    else $error("result strobe without a count update");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kmnc_pkg::ST_CNT_RD) |-> (best_r <= last_r))
    else $error("nearest entry lies beyond the searched range");

  a_dist_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.vld |-> (state_r == kmnc_pkg::ST_SCAN || state_r == kmnc_pkg::ST_DRAIN))
    else $error("distance result outside a classify transaction");
`endif

endmodule

/* tb/tb_kmeans_nearest_centroid_unit.sv */
// Self-checking testbench for the k-means nearest-centroid unit.
// Drives load, clear and classify transactions and checks each result against its own
// search predictor or a given value. Depends on kmnc_pkg and kmeans_nearest_centroid_unit.
`timescale 1ns / 1ps

module tb_kmeans_nearest_centroid_unit;

  localparam int NUM_ENTRIES   = kmnc_pkg::MAX_CENTROIDS_DEF;
  localparam int COORD_W       = kmnc_pkg::COORD_WIDTH_DEF;
  localparam int COUNT_W       = kmnc_pkg::COUNT_WIDTH_DEF;
  localparam int MODE_W        = kmnc_pkg::MODE_W;
  localparam int ENTRY_W       = kmnc_pkg::ENTRY_W;
  localparam int NUMC_W        = kmnc_pkg::NUMC_W;
  localparam int CLUSTER_W     = kmnc_pkg::CLUSTER_W;
  localparam int SETTLE_CYCLES = NUM_ENTRIES + 32;
  localparam int MAX_REPORTS   = 10;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] ONE_Q12   = 24'sd4096;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [COUNT_W-1:0]   count;
  } assignment_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [MODE_W-1:0]           mode;
    logic [ENTRY_W-1:0]          entry;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic signed [COORD_W-1:0]   z;
    logic [NUMC_W-1:0]           numc;
    logic                        typed;
    logic [CLUSTER_W-1:0]        exp_cluster;
    logic [COUNT_W-1:0]          exp_count;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [MODE_W-1:0]         in_mode;
  logic [ENTRY_W-1:0]        in_entry_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic signed [COORD_W-1:0] in_coord_z;
  logic                      out_valid;
  logic [CLUSTER_W-1:0]      out_nearest_cluster;
  logic [COUNT_W-1:0]        out_cluster_count;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [NUMC_W-1:0]         cfg_num_centroids;

  // Shadow copy of the block's tables and register.
  logic signed [COORD_W-1:0] cent_x [NUM_ENTRIES];
  logic signed [COORD_W-1:0] cent_y [NUM_ENTRIES];
  logic signed [COORD_W-1:0] cent_z [NUM_ENTRIES];
  logic [COUNT_W-1:0]        cluster_tally [NUM_ENTRIES];
  logic [NUMC_W-1:0]         num_centroids_shadow;

  assignment_t pending_assignments [$];
  stim_row_t   directed_rows [$];
  assignment_t monitor_want;
  int          mismatches = 0;
  int          sender_idle_pct = 0;

  kmeans_nearest_centroid_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_entry_index      (in_entry_index),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .out_valid           (out_valid),
    .out_nearest_cluster (out_nearest_cluster),
    .out_cluster_count   (out_cluster_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_num_centroids   (cfg_num_centroids)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int searched_entries();
    int n;
    n = num_centroids_shadow;
    if (n == 0) n = 1;
    if (n > NUM_ENTRIES) n = NUM_ENTRIES;
    return n;
  endfunction

  // Exact integer search: squares of 25-bit differences fit easily in 64 bits.
  function automatic assignment_t classify_point(input logic signed [COORD_W-1:0] px,
                                                 input logic signed [COORD_W-1:0] py,
                                                 input logic signed [COORD_W-1:0] pz);
    int          n;
    int          best;
    longint      dx;
    longint      dy;
    longint      dz;
    longint      sq_sum;
    longint      best_dist;
    assignment_t r;
    n = searched_entries();
    best = 0;
    best_dist = 0;
    for (int e = 0; e < n; e++) begin
      dx = px - cent_x[e];
      dy = py - cent_y[e];
      dz = pz - cent_z[e];
      sq_sum = dx * dx + dy * dy + dz * dz;
      if (e == 0 || sq_sum < best_dist) begin
        best = e;
        best_dist = sq_sum;
      end
    end
    if (cluster_tally[best] != {COUNT_W{1'b1}}) cluster_tally[best] = cluster_tally[best] + 1'b1;
    r.cluster = CLUSTER_W'(best);
    r.count = cluster_tally[best];
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return COORD_W'($urandom_range(0, 16383) - 8192);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Presents one transaction and holds it until the block takes it, then updates the
  // shadow state. Returns in the time step of acceptance without touching start.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ENTRY_W-1:0] entry,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input logic typed, input logic [CLUSTER_W-1:0] exp_cluster,
                           input logic [COUNT_W-1:0] exp_count);
    assignment_t got;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= entry;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    do @(posedge clk); while (busy !== 1'b0);
    case (mode)
      kmnc_pkg::MODE_LOAD: begin
        cent_x[entry] = x;
        cent_y[entry] = y;
        cent_z[entry] = z;
      end
      kmnc_pkg::MODE_CLEAR: begin
        for (int i = 0; i < NUM_ENTRIES; i++) cluster_tally[i] = '0;
      end
      kmnc_pkg::MODE_CLASSIFY: begin
        got = classify_point(x, y, z);
        if (typed) begin
          got.cluster = exp_cluster;
          got.count = exp_count;
        end
        pending_assignments.push_back(got);
      end
      default: ;
    endcase
  endtask

  // The register is only written once every result is in and a clear sweep or a
  // classify search that produces nothing more has had time to finish.
  task automatic write_num_centroids(input logic [NUMC_W-1:0] value);
    start <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_num_centroids <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    num_centroids_shadow = value;
  endtask

  task automatic add_item(input logic [MODE_W-1:0] mode, input int entry,
                          input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y,
                          input logic signed [COORD_W-1:0] z,
                          input logic typed, input int exp_cluster, input int exp_count);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.mode = mode;
    row.entry = ENTRY_W'(entry);
    row.x = x;
    row.y = y;
    row.z = z;
    row.typed = typed;
    row.exp_cluster = CLUSTER_W'(exp_cluster);
    row.exp_count = COUNT_W'(exp_count);
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input int value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.numc = NUMC_W'(value);
    directed_rows.push_back(row);
  endtask

  // Mostly classify and load transactions; loads often copy another entry's
  // coordinates and points often sit on or next to a centroid, so ties are common.
  task automatic random_phase(input int numc_value, input int item_count);
    int                        done;
    int                        pick;
    int                        eff;
    int                        src;
    logic [MODE_W-1:0]         mode;
    logic [ENTRY_W-1:0]        entry;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    write_num_centroids(NUMC_W'(numc_value));
    eff = searched_entries();
    done = 0;
    while (done < item_count) begin
      pick = $urandom_range(0, 99);
      entry = ENTRY_W'($urandom);
      px = rand_coord();
      py = rand_coord();
      pz = rand_coord();
      if (pick < 55) begin
        mode = kmnc_pkg::MODE_CLASSIFY;
        src = $urandom_range(0, eff - 1);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          px = cent_x[src];
          py = cent_y[src];
          pz = cent_z[src];
        end else if (pick < 60) begin
          px = cent_x[src] + $signed(4'($urandom_range(0, 6) - 3));
          py = cent_y[src] + $signed(4'($urandom_range(0, 6) - 3));
          pz = cent_z[src] + $signed(4'($urandom_range(0, 6) - 3));
        end
      end else if (pick < 87) begin
        mode = kmnc_pkg::MODE_LOAD;
        if ($urandom_range(0, 9) < 6) entry = ENTRY_W'($urandom_range(0, eff - 1));
        if ($urandom_range(0, 4) == 0) begin
          src = $urandom_range(0, NUM_ENTRIES - 1);
          px = cent_x[src];
          py = cent_y[src];
          pz = cent_z[src];
        end
      end else if (pick < 91) begin
        mode = kmnc_pkg::MODE_CLEAR;
      end else begin
        mode = MODE_UNUSED;
      end
      send_item(mode, entry, px, py, pz, 1'b0, '0, '0);
      if (mode != MODE_UNUSED) done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_assignments.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result cluster %0d count %0d",
                   out_nearest_cluster, out_cluster_count);
      end else begin
        monitor_want = pending_assignments.pop_front();
        if (out_nearest_cluster !== monitor_want.cluster ||
            out_cluster_count !== monitor_want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: expected cluster %0d count %0d, got cluster %0d count %0d",
                     monitor_want.cluster, monitor_want.count,
                     out_nearest_cluster, out_cluster_count);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    stim_row_t row;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_mode           <= kmnc_pkg::MODE_LOAD;
    in_entry_index    <= '0;
    in_coord_x        <= '0;
    in_coord_y        <= '0;
    in_coord_z        <= '0;
    cfg_valid         <= 1'b0;
    cfg_num_centroids <= '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      cent_x[i] = '0;
      cent_y[i] = '0;
      cent_z[i] = '0;
      cluster_tally[i] = '0;
    end
    num_centroids_shadow = 1;

    // One entry searched after reset; extremes of every axis on both sides.
    add_item(kmnc_pkg::MODE_LOAD, 0, 0, 0, 0, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, 0, 0, 0, 1'b1, 0, 1);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 0, 2);
    add_item(kmnc_pkg::MODE_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 0, 3);
    // The unused mode must change nothing and produce no result.
    add_item(MODE_UNUSED, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 0, 4);
    add_item(kmnc_pkg::MODE_CLEAR, 0, 0, 0, 0, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, 0, 0, 0, 1'b1, 0, 1);
    add_item(kmnc_pkg::MODE_LOAD, 1, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_LOAD, 2, ONE_Q12, 0, 0, 1'b0, 0, 0);
    add_item(kmnc_pkg::MODE_LOAD, 3, -ONE_Q12, 0, 0, 1'b0, 0, 0);
    add_cfg(4);
    // Entries 2 and 3 are equally far from the origin, so the lower index wins.
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, 0, 0, 0, 1'b1, 2, 1);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1, 1);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, 0, 0, 1, 1'b1, 2, 2);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, -1, 0, 0, 1'b1, 3, 1);
    // A zero register searches entry 0 alone.
    add_cfg(0);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, 0, 0, 0, 1'b1, 0, 2);
    add_item(kmnc_pkg::MODE_LOAD, NUM_ENTRIES - 1, 1, -1, 1, 1'b0, 0, 0);
    add_cfg(1);
    add_item(kmnc_pkg::MODE_CLASSIFY, 0, COORD_MIN, COORD_MAX, 0, 1'b1, 0, 3);

    sender_idle_pct = 24;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        write_num_centroids(row.numc);
      end else begin
        send_item(row.mode, row.entry, row.x, row.y, row.z,
                  row.typed, row.exp_cluster, row.exp_count);
      end
    end

    // Fill the whole table so that any register setting searches defined entries only.
    for (int e = 0; e < NUM_ENTRIES; e++)
      send_item(kmnc_pkg::MODE_LOAD, ENTRY_W'(e), rand_coord(), rand_coord(), rand_coord(),
                1'b0, '0, '0);

    random_phase(5, 150);
    random_phase(NUM_ENTRIES, 8);
    random_phase(2, 40);

    sender_idle_pct = 82;
    random_phase(0, 30);
    random_phase(13, 150);
    random_phase(2047, 6);

    sender_idle_pct = 0;
    random_phase(NUM_ENTRIES - 1, 4);
    random_phase(32, 150);
    random_phase(3, 40);

    start <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_assignments.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kmnc_pkg.sv
rtl/kmnc_dist_unit.sv
rtl/kmeans_nearest_centroid_unit.sv
tb/tb_kmeans_nearest_centroid_unit.sv
